// File: hw/rtl/lcg_modular_random_generator_unit_macros.svh
`ifndef LCG_MODULAR_RANDOM_GENERATOR_UNIT_MACROS_SVH
`define LCG_MODULAR_RANDOM_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LCG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcg check failed");

// next-cycle implication
`define LCG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcg check failed");

`endif

// File: hw/rtl/lcg_pkg.sv
package lcg_pkg;

    localparam int STATE_W = 63;
    localparam int FRAC_W  = 32;
    localparam int M31_W   = 31;
    localparam int SH31_W  = STATE_W + M31_W;
    localparam int CNT_MAX = (STATE_W > FRAC_W) ? STATE_W : FRAC_W;
    localparam int CNT_W   = $clog2(CNT_MAX);

    localparam logic [M31_W-1:0] M31_P = '1;

    localparam logic [63:0] RST_MULT_64 = 64'd561860773102413563;
    localparam logic [63:0] RST_MOD_64  = 64'd1152921504606846883;
    localparam logic [STATE_W-1:0] RST_MULT = RST_MULT_64[STATE_W-1:0];
    localparam logic [STATE_W-1:0] RST_MOD  = RST_MOD_64[STATE_W-1:0];

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_SEED  = 2'd1,
        ERR_PARAM = 2'd2
    } lcg_err_t;

    typedef enum logic [1:0] {
        REG_MULT = 2'd0,
        REG_INC  = 2'd1,
        REG_MOD  = 2'd2
    } lcg_reg_t;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_SEED = 1'b1;

    // result of the shared modular adder
    typedef struct packed {
        logic               ge;
        logic [STATE_W-1:0] res;
    } lcg_am_t;

endpackage

// File: hw/rtl/lcg_modular_random_generator_unit.sv
// Linear congruential generator with run-time multiplier a, increment c and modulus m.
// A draw request (req_type 0) replaces the state s by (a*s + c) mod m and returns the new
// state, state mod 2147483647 and floor(state*2^32/m) (all ones when state >= m); if
// a == 0, a >= m or c >= m the draw reports error 2 and keeps the state. A seed request
// (req_type 1) loads seed_value when 0 < seed < m, else reports error 1. State resets to 1.
// Everything runs through one shared 63-bit add/compare-subtract unit, one use per cycle:
// a draw scans s one bit per cycle for s mod m, then a one bit per S_MUL_DBL/S_MUL_ADD
// pair for the modular multiply, then 32 restoring steps for the fraction; a seed or
// rejected request skips the reduction and the multiply. One request is in flight at
// a time; a finished result waits in the output register while the next request is
// taken. Registers must be written only while idle; the block does not enforce this.
`include "lcg_modular_random_generator_unit_macros.svh"

module lcg_modular_random_generator_unit import lcg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [STATE_W-1:0] cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [STATE_W-1:0] seed_value,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [STATE_W-1:0] state_value,
    output logic [M31_W-1:0]   int31_value,
    output logic [FRAC_W-1:0]  uniform_frac,
    output logic [1:0]         error_code
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SEED_CHK = 11'b000_0000_0010,
        S_PCHK_A   = 11'b000_0000_0100,
        S_PCHK_C   = 11'b000_0000_1000,
        S_REDUCE   = 11'b000_0001_0000,
        S_MUL_DBL  = 11'b000_0010_0000,
        S_MUL_ADD  = 11'b000_0100_0000,
        S_ADD_C    = 11'b000_1000_0000,
        S_FRAC_CHK = 11'b001_0000_0000,
        S_FRAC     = 11'b010_0000_0000,
        S_FIN      = 11'b100_0000_0000
    } fsm_t;

    localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(STATE_W - 1);
    localparam logic [CNT_W-1:0] LAST_FRAC = CNT_W'(FRAC_W - 1);

    fsm_t               fsm_reg, fsm_next;
    logic [STATE_W-1:0] mult_reg, inc_reg, mod_reg;
    logic [STATE_W-1:0] cur_reg, cur_next;
    logic [STATE_W-1:0] work_reg, work_next;
    logic [STATE_W-1:0] x_reg, x_next;
    logic [STATE_W-1:0] sh_reg, sh_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [FRAC_W-1:0]  q_reg, q_next;
    logic               sat_reg, sat_next;
    lcg_err_t           err_reg, err_next;

    logic               out_valid_reg, out_valid_next;
    logic [STATE_W-1:0] o_state_reg;
    logic [M31_W-1:0]   o_int31_reg;
    logic [FRAC_W-1:0]  o_frac_reg;
    lcg_err_t           o_err_reg;

    logic [STATE_W-1:0] am_p, am_q;
    logic               am_cin;
    lcg_am_t            am;
    logic               m31_start;
    logic [M31_W-1:0]   m31_rem;
    logic               out_load;

    lcg_addmod u_addmod (
        .p   (am_p),
        .q   (am_q),
        .cin (am_cin),
        .m   (mod_reg),
        .am  (am)
    );

    assign m31_start = (fsm_reg == S_FRAC_CHK);

    lcg_m31 u_m31 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (m31_start),
        .value (cur_reg),
        .rem   (m31_rem)
    );

    assign in_ready = (fsm_reg == S_IDLE);
    assign out_load = (fsm_reg == S_FIN) && (!out_valid_reg || out_ready);

    // operand select for the shared adder
    always_comb
    begin
        am_p   = work_reg;
        am_q   = '0;
        am_cin = 1'b0;
        unique case (fsm_reg)
            S_SEED_CHK: am_p = x_reg;
            S_PCHK_A:   am_p = mult_reg;
            S_PCHK_C:   am_p = inc_reg;
            S_REDUCE:
            begin
                am_q   = work_reg;
                am_cin = sh_reg[STATE_W-1];
            end
            S_MUL_DBL:  am_q = work_reg;
            S_MUL_ADD:  am_q = sh_reg[STATE_W-1] ? x_reg : '0;
            S_ADD_C:    am_q = inc_reg;
            S_FRAC_CHK: am_p = cur_reg;
            S_FRAC:     am_q = work_reg;
            default:    am_p = work_reg;
        endcase
    end

    always_comb
    begin
        fsm_next  = fsm_reg;
        cur_next  = cur_reg;
        work_next = work_reg;
        x_next    = x_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        err_next  = err_reg;
        unique case (fsm_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    err_next = ERR_OK;
                    x_next   = seed_value;
                    fsm_next = (req_type == REQ_SEED) ? S_SEED_CHK : S_PCHK_A;
                end
            end
            S_SEED_CHK:
            begin
                if (am.ge || (x_reg == '0))
                    err_next = ERR_SEED;
                else
                    cur_next = x_reg;
                fsm_next = S_FRAC_CHK;
            end
            S_PCHK_A:
            begin
                if (am.ge || (mult_reg == '0))
                begin
                    err_next = ERR_PARAM;
                    fsm_next = S_FRAC_CHK;
                end
                else
                    fsm_next = S_PCHK_C;
            end
            S_PCHK_C:
            begin
                if (am.ge)
                begin
                    err_next = ERR_PARAM;
                    fsm_next = S_FRAC_CHK;
                end
                else
                begin
                    sh_next   = cur_reg;
                    work_next = '0;
                    cnt_next  = '0;
                    fsm_next  = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                // work = (2*work + next bit of s) mod m
                work_next = am.res;
                sh_next   = sh_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT)
                begin
                    x_next    = am.res;
                    work_next = '0;
                    sh_next   = mult_reg;
                    cnt_next  = '0;
                    fsm_next  = S_MUL_DBL;
                end
            end
            S_MUL_DBL:
            begin
                work_next = am.res;
                fsm_next  = S_MUL_ADD;
            end
            S_MUL_ADD:
            begin
                work_next = am.res;
                sh_next   = sh_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
                fsm_next  = (cnt_reg == LAST_BIT) ? S_ADD_C : S_MUL_DBL;
            end
            S_ADD_C:
            begin
                cur_next = am.res;
                fsm_next = S_FRAC_CHK;
            end
            S_FRAC_CHK:
            begin
                sat_next  = am.ge;
                work_next = cur_reg;
                cnt_next  = '0;
                fsm_next  = S_FRAC;
            end
            S_FRAC:
            begin
                // restoring step: quotient bit is the compare result
                work_next = am.res;
                q_next    = {q_reg[FRAC_W-2:0], am.ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_FRAC)
                    fsm_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_load)
                    fsm_next = S_IDLE;
            end
            default:
                fsm_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= STATE_W'(1);
            mult_reg      <= RST_MULT;
            inc_reg       <= '0;
            mod_reg       <= RST_MOD;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MULT: mult_reg <= cfg_data;
                    REG_INC:  inc_reg  <= cfg_data;
                    REG_MOD:  mod_reg  <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        x_reg    <= x_next;
        sh_reg   <= sh_next;
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
        sat_reg  <= sat_next;
        err_reg  <= err_next;
        if (out_load)
        begin
            o_state_reg <= cur_reg;
            o_int31_reg <= m31_rem;
            o_frac_reg  <= sat_reg ? '1 : q_reg;
            o_err_reg   <= err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign state_value  = o_state_reg;
    assign int31_value  = o_int31_reg;
    assign uniform_frac = o_frac_reg;
    assign error_code   = o_err_reg;

    `LCG_ASSERT_IMP(a_mul_operand_reduced, fsm_reg == S_MUL_ADD, x_reg < mod_reg)
    `LCG_ASSERT_IMP(a_frac_rem_below_mod, (fsm_reg == S_FRAC) && !sat_reg, work_reg < mod_reg)
    `LCG_ASSERT_NXT(a_draw_state_reduced, fsm_reg == S_ADD_C, cur_reg < mod_reg)
    `LCG_ASSERT_IMP(a_int31_in_range, fsm_reg == S_FIN, m31_rem != M31_P)

endmodule

// File: hw/rtl/lcg_addmod.sv
// t = p + q + cin; ge = (t >= m); res = ge ? t - m : t
module lcg_addmod import lcg_pkg::*;
(
    input  logic [STATE_W-1:0] p,
    input  logic [STATE_W-1:0] q,
    input  logic               cin,
    input  logic [STATE_W-1:0] m,
    output lcg_am_t            am
);

    logic [STATE_W:0]   sum;
    logic [STATE_W+1:0] diff;

    assign sum  = {1'b0, p} + {1'b0, q} + {{STATE_W{1'b0}}, cin};
    assign diff = {1'b0, sum} - {2'b00, m};

    assign am.ge  = ~diff[STATE_W+1];
    assign am.res = am.ge ? diff[STATE_W-1:0] : sum[STATE_W-1:0];

endmodule

// File: hw/rtl/lcg_m31.sv
// value mod (2^31 - 1), one 31-bit digit per cycle; the result holds once the digit shifter runs empty.
module lcg_m31 import lcg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [STATE_W-1:0] value,
    output logic [M31_W-1:0]   rem
);

    logic [SH31_W-1:0] sh_reg;
    logic [SH31_W-1:0] sh_next;
    logic [M31_W-1:0]  acc_reg;
    logic [M31_W-1:0]  acc_next;
    logic [M31_W:0]    sum;
    logic [M31_W-1:0]  fold;

    assign sum  = {1'b0, acc_reg} + {1'b0, sh_reg[M31_W-1:0]};
    // end-around carry; result is at most P, and P itself means zero
    assign fold = sum[M31_W-1:0] + {{(M31_W-1){1'b0}}, sum[M31_W]};

    always_comb
    begin
        if (start)
        begin
            sh_next  = {{M31_W{1'b0}}, value};
            acc_next = '0;
        end
        else
        begin
            sh_next  = sh_reg >> M31_W;
            acc_next = (fold == M31_P) ? '0 : fold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg  <= '0;
            acc_reg <= '0;
        end
        else
        begin
            sh_reg  <= sh_next;
            acc_reg <= acc_next;
        end
    end

    assign rem = acc_reg;

endmodule

// File: verif/lcg_result_checker.sv
module lcg_result_checker import lcg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [STATE_W-1:0] cfg_data,

    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               req_type,
    input  logic [STATE_W-1:0] seed_value,

    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [STATE_W-1:0] state_value,
    input  logic [M31_W-1:0]   int31_value,
    input  logic [FRAC_W-1:0]  uniform_frac,
    input  logic [1:0]         error_code,

    output int                 fail_count,
    output int                 pending,
    output int                 checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [M31_W-1:0]   int31;
        logic [FRAC_W-1:0]  frac;
        lcg_err_t           err;
    } lcg_result_t;

    lcg_result_t        expected_q[$];
    logic [STATE_W-1:0] mult_r;
    logic [STATE_W-1:0] inc_r;
    logic [STATE_W-1:0] mod_r;
    logic [STATE_W-1:0] state_r;
    int                 mismatches;
    int                 results_seen;

    // (a*s + c) mod m, exact in 128 bits
    function automatic logic [STATE_W-1:0] lcg_advance(input logic [STATE_W-1:0] a,
                                                       input logic [STATE_W-1:0] s,
                                                       input logic [STATE_W-1:0] c,
                                                       input logic [STATE_W-1:0] m);
        logic [127:0] acc;
        acc = 128'(s) % 128'(m);
        acc = acc * 128'(a) + 128'(c);
        acc = acc % 128'(m);
        return acc[STATE_W-1:0];
    endfunction

    // floor(s*2^32/m), all ones once the state is not below m
    function automatic logic [FRAC_W-1:0] fraction_of(input logic [STATE_W-1:0] s,
                                                      input logic [STATE_W-1:0] m);
        logic [127:0] q;
        if (s >= m)
            return '1;
        q = (128'(s) << FRAC_W) / 128'(m);
        return q[FRAC_W-1:0];
    endfunction

    function automatic lcg_result_t serve_request(input logic req,
                                                  input logic [STATE_W-1:0] seed);
        lcg_result_t r;
        r.err = ERR_OK;
        if (req == REQ_SEED)
        begin
            if (seed == '0 || seed >= mod_r)
                r.err = ERR_SEED;
            else
                state_r = seed;
        end
        else if (mult_r == '0 || mult_r >= mod_r || inc_r >= mod_r)
        begin
            r.err = ERR_PARAM;
        end
        else
        begin
            state_r = lcg_advance(mult_r, state_r, inc_r, mod_r);
        end
        r.state = state_r;
        r.int31 = M31_W'(64'(state_r) % 64'(M31_P));
        r.frac  = fraction_of(state_r, mod_r);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        lcg_result_t exp_r;
        if (!rst_n)
        begin
            mult_r       = RST_MULT;
            inc_r        = '0;
            mod_r        = RST_MOD;
            state_r      = STATE_W'(1);
            mismatches   = 0;
            results_seen = 0;
            expected_q.delete();
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MULT: mult_r = cfg_data;
                    REG_INC:  inc_r  = cfg_data;
                    REG_MOD:  mod_r  = cfg_data;
                    default:  ;
                endcase
            end
            if (in_valid && in_ready)
                expected_q.push_back(serve_request(req_type, seed_value));
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request outstanding: state %h err %0d",
                                 $realtime, state_value, error_code);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.state !== state_value || exp_r.int31 !== int31_value ||
                        exp_r.frac !== uniform_frac || exp_r.err !== error_code)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result %0d differs (expected / actual)",
                                     $realtime, results_seen);
                            $display("    state %h / %h  int31 %h / %h", exp_r.state,
                                     state_value, exp_r.int31, int31_value);
                            $display("    frac %h / %h  err %0d / %0d", exp_r.frac,
                                     uniform_frac, exp_r.err, error_code);
                        end
                    end
                end
            end
            fail_count <= mismatches;
            pending    <= expected_q.size();
            checked    <= results_seen;
        end
    end

endmodule

// File: verif/lcg_modular_random_generator_unit_test.sv
module lcg_modular_random_generator_unit_test import lcg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]         REG_SPARE    = 2'd3;
    localparam logic [STATE_W-1:0] MAX_STATE    = '1;
    localparam int                 RANDOM_ITEMS = 1680;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [STATE_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic [STATE_W-1:0] seed_value;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [STATE_W-1:0] state_value;
    logic [M31_W-1:0]   int31_value;
    logic [FRAC_W-1:0]  uniform_frac;
    logic [1:0]         error_code;

    int                 fail_count;
    int                 pending;
    int                 checked;

    logic [STATE_W-1:0] mod_now;
    int                 burst_left;
    int                 n_draws;
    int                 n_seeds;
    int                 n_random;
    int                 n_settings;
    int                 ready_mode = 0;
    int                 ready_left = 0;

    lcg_modular_random_generator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .state_value  (state_value),
        .int31_value  (int31_value),
        .uniform_frac (uniform_frac),
        .error_code   (error_code)
    );

    lcg_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .state_value  (state_value),
        .int31_value  (int31_value),
        .uniform_frac (uniform_frac),
        .error_code   (error_code),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: switches between free-running, coin-flip, periodic and mostly-stalled
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(50, 1200);
        end
        else
        begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (ready_left % 5 == 0);
            default: out_ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    function automatic logic [STATE_W-1:0] rand_below(input logic [63:0] n);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return STATE_W'(r % n);
    endfunction

    // uniform-ish value in [lo, MAX_STATE]
    function automatic logic [STATE_W-1:0] rand_from(input logic [63:0] lo);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return STATE_W'(lo + r % (64'(MAX_STATE) - lo + 64'd1));
    endfunction

    task automatic send(input logic req, input logic [STATE_W-1:0] seed);
        int gap;
        int pick;
        if (burst_left == 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                gap = 0;
            else if (pick < 85)
                gap = $urandom_range(1, 8);
            else
                gap = $urandom_range(9, 240);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        seed_value <= seed;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (req == REQ_SEED)
            n_seeds++;
        else
            n_draws++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic load_params(input logic [STATE_W-1:0] a, input logic [STATE_W-1:0] c,
                               input logic [STATE_W-1:0] m, input bit spare_write);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MULT;
        cfg_data  <= a;
        @(posedge clk);
        cfg_index <= REG_INC;
        cfg_data  <= c;
        @(posedge clk);
        cfg_index <= REG_MOD;
        cfg_data  <= m;
        @(posedge clk);
        // unmapped index must not disturb anything
        if (spare_write)
        begin
            cfg_index <= REG_SPARE;
            cfg_data  <= rand_from(64'd0);
            @(posedge clk);
        end
        cfg_we  <= 1'b0;
        mod_now = m;
        n_settings++;
    endtask

    task automatic random_requests(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send(REQ_DRAW, rand_from(64'd0));
            else if (pick < 88)
                send(REQ_SEED, (mod_now > 1) ? rand_below(64'(mod_now) - 1) + 1'b1 : '1);
            else if (pick < 92)
                send(REQ_SEED, '0);
            else if (pick < 96)
                send(REQ_SEED, rand_from(64'(mod_now)));
            else
                send(REQ_SEED, rand_from(64'd0));
            n_random++;
        end
    endtask

    task automatic random_setting();
        logic [63:0]        m;
        logic [STATE_W-1:0] a;
        logic [STATE_W-1:0] c;
        int                 w;
        w = $urandom_range(2, STATE_W);
        m = {$urandom, $urandom} & ((64'd1 << w) - 1);
        m[w-1] = 1'b1;
        a = rand_below(m - 1) + 1'b1;
        c = rand_below(m);
        case ($urandom_range(0, 9))
            0:       a = '0;
            1:       a = rand_from(m);
            2:       c = rand_from(m);
            default: ;
        endcase
        load_params(a, c, STATE_W'(m), $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_MULT;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = REQ_DRAW;
        seed_value = '0;
        burst_left = 0;
        n_draws    = 0;
        n_seeds    = 0;
        n_random   = 0;
        n_settings = 1;
        mod_now    = RST_MOD;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // power-on parameters, state starts at 1
        send(REQ_DRAW, MAX_STATE);
        send(REQ_DRAW, '0);
        send(REQ_SEED, STATE_W'(1));
        send(REQ_DRAW, '0);
        send(REQ_SEED, '0);
        send(REQ_SEED, RST_MOD);
        send(REQ_SEED, RST_MOD - 1'b1);
        send(REQ_DRAW, '0);
        send(REQ_SEED, MAX_STATE);
        send(REQ_SEED, 63'h0AAA_AAAA_AAAA_AAAA);
        send(REQ_DRAW, '0);
        send(REQ_SEED, RST_MOD + 1'b1);

        // widest modulus, largest multiplier and increment
        load_params(MAX_STATE - 1'b1, MAX_STATE - 1'b1, MAX_STATE, 1'b1);
        send(REQ_SEED, MAX_STATE - 1'b1);
        send(REQ_DRAW, '0);
        send(REQ_SEED, MAX_STATE);
        send(REQ_DRAW, '0);
        random_requests(150);

        // smallest legal modulus
        load_params(STATE_W'(1), STATE_W'(1), STATE_W'(2), 1'b0);
        send(REQ_DRAW, '0);
        send(REQ_SEED, STATE_W'(2));
        send(REQ_SEED, STATE_W'(1));
        random_requests(60);

        // composite modulus: the state collapses to zero and stays there
        load_params(STATE_W'(6), STATE_W'(0), STATE_W'(12), 1'b0);
        send(REQ_SEED, STATE_W'(2));
        send(REQ_DRAW, '0);
        send(REQ_DRAW, '0);
        send(REQ_SEED, STATE_W'(5));
        send(REQ_DRAW, '0);
        random_requests(60);

        // big state left over after the modulus shrinks
        load_params(MAX_STATE - 1'b1, '0, MAX_STATE, 1'b0);
        send(REQ_SEED, 63'h4000_0000_0000_3039);
        load_params(STATE_W'(5), STATE_W'(3), STATE_W'(97), 1'b1);
        send(REQ_SEED, '0);
        send(REQ_DRAW, '0);
        random_requests(40);

        // bad parameters: zero multiplier, multiplier at m, increment at m
        load_params(STATE_W'(0), STATE_W'(5), STATE_W'(1000), 1'b1);
        send(REQ_DRAW, '0);
        send(REQ_SEED, STATE_W'(7));
        random_requests(40);
        load_params(STATE_W'(1000), STATE_W'(5), STATE_W'(1000), 1'b0);
        random_requests(30);
        load_params(STATE_W'(3), STATE_W'(1000), STATE_W'(1000), 1'b0);
        random_requests(30);

        // classic 31-bit prime modulus
        load_params(STATE_W'(16807), '0, STATE_W'(M31_P), 1'b0);
        random_requests(150);

        while (n_random < RANDOM_ITEMS)
        begin
            random_setting();
            random_requests(120);
        end

        settle();
        repeat (300) @(posedge clk);
        $display("%0d requests (%0d draws, %0d seeds) under %0d parameter settings,",
                 n_draws + n_seeds, n_draws, n_seeds, n_settings);
        $display("%0d results compared against the predicted sequence", checked);
        if (fail_count == 0)
            $display("lcg_modular_random_generator_unit: match");
        else
            $display("lcg_modular_random_generator_unit: mismatch");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("timeout with %0d results outstanding", pending);
        $display("lcg_modular_random_generator_unit: mismatch");
        $finish;
    end

endmodule
